// File: design/pcsp_pkg.sv
// Shared types, constants and scale tables for the plot command stream parser.
// Depends on nothing; every other design file imports it.
`timescale 1ns / 1ps

package pcsp_pkg;

  // Constant power of ten, evaluated at elaboration only
  function automatic longint unsigned pow10(input int n);
    longint unsigned p;
    p = 64'd1;
    for (int i = 0; i < n; i++) begin
      p = p * 64'd10;
    end
    return p;
  endfunction

  // Digit word limits
  localparam int MAX_DIGITS = 10;
  localparam int COORD_BITS = 58;

  // A coordinate word is held as hi*10 + lo, lo being the last digit taken
  localparam longint unsigned ACC_HI_LIMIT = pow10(MAX_DIGITS - 1);
  localparam longint unsigned ACC_HI_SAT   = pow10(MAX_DIGITS - 2);
  localparam int              ACC_HI_BITS  = $clog2(ACC_HI_LIMIT);

  // Configuration port
  localparam int PADDR_BITS = 4;
  localparam int PDATA_BITS = 32;
  localparam logic [1:0] REG_X_DECIMALS = 2'd0;
  localparam logic [1:0] REG_Y_DECIMALS = 2'd1;
  localparam logic [1:0] REG_INCH_UNITS = 2'd2;

  // Characters of interest
  localparam logic [7:0] CH_LF  = 8'd10;
  localparam logic [7:0] CH_CR  = 8'd13;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_0   = 8'h30;
  localparam logic [7:0] CH_9   = 8'h39;
  localparam logic [7:0] CH_D   = 8'h44;
  localparam logic [7:0] CH_X   = 8'h58;
  localparam logic [7:0] CH_Y   = 8'h59;

  // Scale factors per decimal count (index 7 repeats 6: counts above six act as six).
  // HI multiplies the word without its last digit, LO multiplies the last digit.
  localparam int SCALE_HI_BITS = 28;
  localparam int SCALE_LO_BITS = 25;
  localparam int FINE_LO_BITS  = 8;

  localparam logic [SCALE_HI_BITS-1:0] SCALE_HI_MM [8] = '{
    28'd10000000, 28'd1000000, 28'd100000, 28'd10000,
    28'd1000, 28'd100, 28'd10, 28'd10
  };
  localparam logic [SCALE_LO_BITS-1:0] SCALE_LO_MM [8] = '{
    25'd1000000, 25'd100000, 25'd10000, 25'd1000,
    25'd100, 25'd10, 25'd1, 25'd1
  };
  localparam logic [SCALE_HI_BITS-1:0] SCALE_HI_IN [8] = '{
    28'd254000000, 28'd25400000, 28'd2540000, 28'd254000,
    28'd25400, 28'd2540, 28'd254, 28'd254
  };
  // inch with six decimals: last digit times 25.4, rounded half up, from FINE_LO_IN
  localparam logic [SCALE_LO_BITS-1:0] SCALE_LO_IN [8] = '{
    25'd25400000, 25'd2540000, 25'd254000, 25'd25400,
    25'd2540, 25'd254, 25'd0, 25'd0
  };
  localparam logic [FINE_LO_BITS-1:0] FINE_LO_IN [16] = '{
    8'd0, 8'd25, 8'd51, 8'd76, 8'd102, 8'd127, 8'd152, 8'd178,
    8'd203, 8'd229, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0
  };

  // Result events
  typedef enum logic [1:0] {
    EV_SEGMENT  = 2'd0,
    EV_APERTURE = 2'd1,
    EV_UNKNOWN  = 2'd2
  } pcsp_event_t;

  // Parser modes
  typedef enum logic [5:0] {
    M_LINE_START = 6'b000001,
    M_IN_LINE    = 6'b000010,
    M_XDIG       = 6'b000100,
    M_YDIG       = 6'b001000,
    M_DCODE      = 6'b010000,
    M_SKIP       = 6'b100000
  } pcsp_mode_t;

  // Configuration register set
  typedef struct packed {
    logic [2:0] x_decimals;
    logic [2:0] y_decimals;
    logic       inch_units;
  } pcsp_cfg_t;

  // One result beat
  typedef struct packed {
    pcsp_event_t           event_res;
    logic [COORD_BITS-1:0] x_from;
    logic [COORD_BITS-1:0] y_from;
    logic [COORD_BITS-1:0] x_to;
    logic [COORD_BITS-1:0] y_to;
    logic [6:0]            code_number;
  } pcsp_res_t;

endpackage

// File: design/pcsp_cfg.sv
// APB-style register file for decimal counts and the inch flag.
// Depends on pcsp_pkg.
`timescale 1ns / 1ps

module pcsp_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pcsp_pkg::PADDR_BITS-1:0] paddr,
  input  logic [pcsp_pkg::PDATA_BITS-1:0] pwdata,
  output logic [pcsp_pkg::PDATA_BITS-1:0] prdata,
  output logic                           pready,
  output pcsp_pkg::pcsp_cfg_t            cfg
);
  import pcsp_pkg::*;

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[3:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_X_DECIMALS: cfg.x_decimals <= pwdata[2:0];
        REG_Y_DECIMALS: cfg.y_decimals <= pwdata[2:0];
        REG_INCH_UNITS: cfg.inch_units <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_X_DECIMALS: prdata[2:0] = cfg.x_decimals;
      REG_Y_DECIMALS: prdata[2:0] = cfg.y_decimals;
      REG_INCH_UNITS: prdata[0]   = cfg.inch_units;
      default: ;
    endcase
  end

endmodule

// File: design/pcsp_scale.sv
// Converts a finished coordinate word to nanometres: hi*KH + lo*KL.
// Depends on pcsp_pkg scale tables.
`timescale 1ns / 1ps

module pcsp_scale (
  input  logic [pcsp_pkg::ACC_HI_BITS-1:0] acc_hi,
  input  logic [3:0]                       acc_lo,
  input  logic [2:0]                       decimals,
  input  logic                             inch_units,
  output logic [pcsp_pkg::COORD_BITS-1:0]  nm
);
  import pcsp_pkg::*;

  localparam int PROD_BITS = ACC_HI_BITS + SCALE_HI_BITS;
  localparam int LO_BITS   = 4 + SCALE_LO_BITS;

  logic [SCALE_HI_BITS-1:0] k_hi;
  logic [SCALE_LO_BITS-1:0] k_lo;
  logic [PROD_BITS-1:0]     hi_prod;
  logic [LO_BITS-1:0]       lo_term;
  logic                     fine_inch;

  assign k_hi      = inch_units ? SCALE_HI_IN[decimals] : SCALE_HI_MM[decimals];
  assign k_lo      = inch_units ? SCALE_LO_IN[decimals] : SCALE_LO_MM[decimals];
  assign fine_inch = inch_units && (decimals >= 3'd6);

  // Main product; the last digit term is a 4-bit multiple or, for inches at
  // six decimals, the rounded 25.4 multiple from a small table
  assign hi_prod = PROD_BITS'(acc_hi) * PROD_BITS'(k_hi);
  assign lo_term = fine_inch ? LO_BITS'(FINE_LO_IN[acc_lo])
                             : LO_BITS'(acc_lo) * LO_BITS'(k_lo);

  // Ten digits of inches stay below 2^58, so the sum never saturates
  assign nm = COORD_BITS'(hi_prod) + COORD_BITS'(lo_term);

endmodule

// File: design/pcsp_parse.sv
// Character parser: mode machine, digit words, pen positions and D code events.
// Depends on pcsp_pkg and pcsp_scale.
`timescale 1ns / 1ps

module pcsp_parse (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 beat,
  input  logic [7:0]           ch,
  input  pcsp_pkg::pcsp_cfg_t  cfg,
  output logic                 push,
  output pcsp_pkg::pcsp_res_t  res
);
  import pcsp_pkg::*;

  pcsp_mode_t              mode, mode_next;
  logic                    line_has_coord, line_has_coord_next;
  logic [ACC_HI_BITS-1:0]  acc_hi, acc_hi_next;
  logic [3:0]              acc_lo, acc_lo_next;
  logic [6:0]              dval, dval_next;
  logic [1:0]              dseen, dseen_next;
  logic [COORD_BITS-1:0]   pos_x, pos_x_next, pos_y, pos_y_next;
  logic [COORD_BITS-1:0]   prev_x, prev_x_next, prev_y, prev_y_next;

  logic                    is_digit;
  logic [3:0]              dig;
  logic [2:0]              word_dec;
  logic [COORD_BITS-1:0]   word_nm;
  logic [6:0]              code_sel;
  logic                    fin_emit;
  pcsp_event_t             fin_ev;
  pcsp_mode_t              base_mode;

  assign is_digit = (ch >= CH_0) && (ch <= CH_9);
  assign dig      = ch[3:0];
  assign word_dec = (mode == M_YDIG) ? cfg.y_decimals : cfg.x_decimals;

  // Scaling of the open word, used when a non-digit closes it
  pcsp_scale u_scale (
    .acc_hi     (acc_hi),
    .acc_lo     (acc_lo),
    .decimals   (word_dec),
    .inch_units (cfg.inch_units),
    .nm         (word_nm)
  );

  // D code value at completion: line end keeps what was read, a second digit extends
  always_comb begin
    code_sel = dval;
    if (ch != CH_LF && dseen == 2'd1 && is_digit) begin
      code_sel = 7'(dval * 7'd10) + 7'(dig);
    end
  end

  // Event classification of a completed D code
  always_comb begin
    fin_emit = 1'b1;
    fin_ev   = EV_UNKNOWN;
    case (code_sel) inside
      [7'd10:7'd127]: fin_ev = EV_APERTURE;
      7'd1, 7'd3: begin
        fin_ev   = EV_SEGMENT;
        fin_emit = line_has_coord;
      end
      7'd2:    fin_emit = 1'b0;
      default: fin_ev = EV_UNKNOWN;
    endcase
  end

  // Result payload
  always_comb begin
    res             = '0;
    res.event_res   = fin_ev;
    res.code_number = code_sel;
    if (fin_ev == EV_SEGMENT) begin
      res.x_from = prev_x;
      res.y_from = prev_y;
      res.x_to   = pos_x;
      res.y_to   = pos_y;
    end
  end

  // Next state for one character beat
  always_comb begin
    mode_next           = mode;
    line_has_coord_next = line_has_coord;
    acc_hi_next         = acc_hi;
    acc_lo_next         = acc_lo;
    dval_next           = dval;
    dseen_next          = dseen;
    pos_x_next          = pos_x;
    pos_y_next          = pos_y;
    prev_x_next         = prev_x;
    prev_y_next         = prev_y;
    base_mode           = mode;
    push                = 1'b0;

    if (beat && ch != CH_CR) begin
      unique case (mode) inside
        M_SKIP: begin
          if (ch == CH_LF) begin
            mode_next           = M_LINE_START;
            line_has_coord_next = 1'b0;
            acc_hi_next         = '0;
            acc_lo_next         = '0;
          end
        end

        M_DCODE: begin
          if (ch == CH_LF) begin
            push                = fin_emit;
            dseen_next          = 2'd0;
            mode_next           = M_LINE_START;
            line_has_coord_next = 1'b0;
            acc_hi_next         = '0;
            acc_lo_next         = '0;
          end else if (dseen == 2'd0) begin
            dval_next  = is_digit ? 7'(dig) : 7'd0;
            dseen_next = is_digit ? 2'd1 : 2'd2;
          end else begin
            push       = fin_emit;
            dval_next  = code_sel;
            dseen_next = 2'd0;
            mode_next  = M_IN_LINE;
          end
        end

        M_LINE_START, M_IN_LINE, M_XDIG, M_YDIG: begin
          if ((mode == M_XDIG || mode == M_YDIG) && is_digit) begin
            // Append a digit, holding at all nines once the word is full
            if (acc_hi >= ACC_HI_BITS'(ACC_HI_SAT)) begin
              acc_hi_next = ACC_HI_BITS'(ACC_HI_LIMIT - 64'd1);
              acc_lo_next = 4'd9;
            end else begin
              acc_hi_next = ACC_HI_BITS'(acc_hi * ACC_HI_BITS'(10)) + ACC_HI_BITS'(acc_lo);
              acc_lo_next = dig;
            end
          end else begin
            // Close an open word
            if (mode == M_XDIG || mode == M_YDIG) begin
              if (mode == M_XDIG) begin
                pos_x_next = word_nm;
              end else begin
                pos_y_next = word_nm;
              end
              acc_hi_next = '0;
              acc_lo_next = '0;
              base_mode   = M_IN_LINE;
            end

            // Character meaning
            if (ch == CH_LF) begin
              mode_next           = M_LINE_START;
              line_has_coord_next = 1'b0;
              acc_hi_next         = '0;
              acc_lo_next         = '0;
            end else if (ch == CH_PCT && base_mode == M_LINE_START) begin
              mode_next = M_SKIP;
            end else if (ch == CH_X || ch == CH_Y) begin
              if (!line_has_coord) begin
                prev_x_next = pos_x;
                prev_y_next = pos_y;
              end
              line_has_coord_next = 1'b1;
              acc_hi_next         = '0;
              acc_lo_next         = '0;
              mode_next           = (ch == CH_X) ? M_XDIG : M_YDIG;
            end else if (ch == CH_D) begin
              dval_next  = '0;
              dseen_next = 2'd0;
              mode_next  = M_DCODE;
            end else begin
              mode_next = M_IN_LINE;
            end
          end
        end

        default: mode_next = M_LINE_START;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode           <= M_LINE_START;
      line_has_coord <= 1'b0;
      acc_hi         <= '0;
      acc_lo         <= '0;
      dval           <= '0;
      dseen          <= '0;
      pos_x          <= '0;
      pos_y          <= '0;
      prev_x         <= '0;
      prev_y         <= '0;
    end else begin
      mode           <= mode_next;
      line_has_coord <= line_has_coord_next;
      acc_hi         <= acc_hi_next;
      acc_lo         <= acc_lo_next;
      dval           <= dval_next;
      dseen          <= dseen_next;
      pos_x          <= pos_x_next;
      pos_y          <= pos_y_next;
      prev_x         <= prev_x_next;
      prev_y         <= prev_y_next;
    end
  end

endmodule

// File: design/pcsp_obuf.sv
// Result register with a skid stage so input beats keep flowing while one result is stalled.
// Depends on pcsp_pkg for the result struct.
`timescale 1ns / 1ps

module pcsp_obuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  pcsp_pkg::pcsp_res_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output pcsp_pkg::pcsp_res_t out_data
);
  import pcsp_pkg::*;

  logic      skid_valid;
  pcsp_res_t skid_data;
  logic      pop;

  assign pop  = out_valid && !out_stall;
  assign full = skid_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        out_data <= skid_data;
      end
    end else if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end
  end

endmodule

// File: design/plot_command_stream_parser_core.sv
// Plot command stream parser, top level: register file, parser, result buffer.
// Depends on pcsp_pkg, pcsp_cfg, pcsp_parse (with pcsp_scale) and pcsp_obuf.
`timescale 1ns / 1ps

// Usage
//   Input channel: one text character per beat on ch (in_valid / in_stall).
//   Output channel: at most one event beat per character (out_valid / out_stall):
//   segment drawn, aperture selected or unknown D code, with positions in nm.
//   Registers (x_decimals, y_decimals, inch_units) are written over the APB-style
//   port at 0x0, 0x4, 0x8 while the stream is idle; pready is always high.
//   The beat that ends a D word registers its event (in the skid entry if the result
//   register is stalled). Throughput: one character per clock unless in_stall; each
//   passes the mode logic and at most one 30x28 coordinate scaler multiply in its cycle.
//   Stall: the result register plus one skid entry absorb output stalls; in_stall
//   rises only when both hold a result, and drops the cycle after a beat leaves.
//   Reset (synchronous, rst high): registers to zero, positions to zero, parser at
//   line start, both result entries empty.
module plot_command_stream_parser_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [pcsp_pkg::PADDR_BITS-1:0]        paddr,
  input  logic [pcsp_pkg::PDATA_BITS-1:0]        pwdata,
  output logic [pcsp_pkg::PDATA_BITS-1:0]        prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic [7:0]                            ch,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic [1:0]                            event_res,
  output logic [pcsp_pkg::COORD_BITS-1:0]        x_from,
  output logic [pcsp_pkg::COORD_BITS-1:0]        y_from,
  output logic [pcsp_pkg::COORD_BITS-1:0]        x_to,
  output logic [pcsp_pkg::COORD_BITS-1:0]        y_to,
  output logic [6:0]                            code_number
);
  import pcsp_pkg::*;

  pcsp_cfg_t cfg;
  pcsp_res_t res, out_res;
  logic      push;
  logic      full;
  logic      beat;

  assign in_stall = full;
  assign beat     = in_valid && !in_stall;

  pcsp_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  pcsp_parse u_parse (
    .clk  (clk),
    .rst  (rst),
    .beat (beat),
    .ch   (ch),
    .cfg  (cfg),
    .push (push),
    .res  (res)
  );

  pcsp_obuf u_obuf (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (res),
    .full      (full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_res)
  );

  // Result fields
  assign event_res   = out_res.event_res;
  assign x_from      = out_res.x_from;
  assign y_from      = out_res.y_from;
  assign x_to        = out_res.x_to;
  assign y_to        = out_res.y_to;
  assign code_number = out_res.code_number;

  // Checks
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no result waiting");

  a_aperture_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_APERTURE) |-> (code_number >= 7'd10))
    else $error("aperture event with a code below ten");

  a_segment_code: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res == EV_SEGMENT) |-> (code_number == 7'd1 || code_number == 7'd3))
    else $error("segment event from a code other than D01 or D03");

  a_nonseg_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && event_res != EV_SEGMENT) |->
      (x_from == '0 && y_from == '0 && x_to == '0 && y_to == '0))
    else $error("non-segment event carries coordinates");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && !in_stall))
    else $error("result buffer not empty after reset");

endmodule

// File: bench/plot_command_stream_parser_core_check.sv
`timescale 1ns / 1ps
// Checker for the plot command stream parser: follows register writes and character
// beats, predicts the event beats and compares them field by field. Uses pcsp_pkg.

module plot_command_stream_parser_core_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic                            pready,
  input  logic [pcsp_pkg::PADDR_BITS-1:0] paddr,
  input  logic [pcsp_pkg::PDATA_BITS-1:0] pwdata,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [7:0]                      ch,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [1:0]                      event_res,
  input  logic [pcsp_pkg::COORD_BITS-1:0] x_from,
  input  logic [pcsp_pkg::COORD_BITS-1:0] y_from,
  input  logic [pcsp_pkg::COORD_BITS-1:0] x_to,
  input  logic [pcsp_pkg::COORD_BITS-1:0] y_to,
  input  logic [6:0]                      code_number,
  output int                              mismatches,
  output int                              events_waiting
);
  import pcsp_pkg::*;

  // ten-digit word saturation value
  localparam longint unsigned WORD_SAT = 64'd9_999_999_999;
  localparam longint unsigned NM_PER_MM = 64'd1_000_000;
  localparam longint unsigned NM_PER_INCH = 64'd25_400_000;

  // register copies
  logic [2:0] xdec, ydec;
  logic       inch;

  // parser state
  logic [COORD_BITS-1:0] pen_x, pen_y, start_x, start_y;
  longint unsigned       word_digits;
  pcsp_mode_t            mode;
  logic                  coord_on_line;
  logic [6:0]            dnum;
  logic [1:0]            dseen;

  pcsp_res_t events_due[$];

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  // digits -> nm, rounded half up, saturating at the coordinate width
  function automatic logic [COORD_BITS-1:0] to_nanometres(input longint unsigned digits,
                                                          input logic [2:0] dec,
                                                          input logic in_inch);
    longint unsigned div, mul, whole, rest, frac, ceiling;
    int places;
    places = (dec > 3'd6) ? 6 : int'(dec);
    div = 64'd1;
    for (int i = 0; i < places; i++) div = div * 64'd10;
    mul = in_inch ? NM_PER_INCH : NM_PER_MM;
    whole = digits / div;
    rest = digits % div;
    frac = (rest * mul + div / 2) / div;
    ceiling = (64'd1 << COORD_BITS) - 64'd1;
    if (whole > (ceiling - frac) / mul) return ceiling[COORD_BITS-1:0];
    return COORD_BITS'(whole * mul + frac);
  endfunction

  task automatic close_line();
    mode = M_LINE_START;
    coord_on_line = 1'b0;
    word_digits = 0;
  endtask

  // D word complete: queue the event it causes, if any
  task automatic close_dword();
    pcsp_res_t r;
    mode = M_IN_LINE;
    dseen = 2'd0;
    r = '0;
    r.code_number = dnum;
    if (dnum >= 7'd10) begin
      r.event_res = EV_APERTURE;
    end else if (dnum == 7'd1 || dnum == 7'd3) begin
      if (!coord_on_line) return;
      r.event_res = EV_SEGMENT;
      r.x_from = start_x;
      r.y_from = start_y;
      r.x_to = pen_x;
      r.y_to = pen_y;
    end else if (dnum == 7'd2) begin
      return;
    end else begin
      r.event_res = EV_UNKNOWN;
    end
    events_due.push_back(r);
  endtask

  // one accepted character
  task automatic parse_char(input logic [7:0] c);
    logic       is_digit;
    logic [3:0] dv;
    is_digit = (c >= CH_0 && c <= CH_9);
    dv = 4'(c - CH_0);
    if (c == CH_CR) return;
    if (mode == M_SKIP) begin
      if (c == CH_LF) close_line();
      return;
    end
    // D word: exactly two characters, or cut short by a line end
    if (mode == M_DCODE) begin
      if (c == CH_LF) begin
        close_dword();
        close_line();
        return;
      end
      if (dseen == 2'd0) begin
        if (is_digit) begin
          dnum = 7'(dv);
          dseen = 2'd1;
        end else begin
          dnum = 7'd0;
          dseen = 2'd2;
        end
        return;
      end
      if (dseen == 2'd1 && is_digit) dnum = 7'(dnum * 10 + dv);
      close_dword();
      return;
    end
    // open coordinate word: digits gather, anything else commits it
    if (mode == M_XDIG || mode == M_YDIG) begin
      if (is_digit) begin
        if (word_digits > (WORD_SAT - dv) / 10) word_digits = WORD_SAT;
        else word_digits = word_digits * 10 + dv;
        return;
      end
      if (mode == M_XDIG) pen_x = to_nanometres(word_digits, xdec, inch);
      else pen_y = to_nanometres(word_digits, ydec, inch);
      word_digits = 0;
      mode = M_IN_LINE;
    end
    if (c == CH_LF) begin
      close_line();
    end else if (c == CH_PCT && mode == M_LINE_START) begin
      mode = M_SKIP;
    end else if (c == CH_X || c == CH_Y) begin
      if (!coord_on_line) begin
        start_x = pen_x;
        start_y = pen_y;
      end
      coord_on_line = 1'b1;
      word_digits = 0;
      mode = (c == CH_X) ? M_XDIG : M_YDIG;
    end else if (c == CH_D) begin
      dnum = 7'd0;
      dseen = 2'd0;
      mode = M_DCODE;
    end else begin
      mode = M_IN_LINE;
    end
  endtask

  // outputs first: an event never leaves in the cycle its character arrives
  always @(posedge clk) begin
    pcsp_res_t want;
    if (rst) begin
      xdec = 3'd0;
      ydec = 3'd0;
      inch = 1'b0;
      pen_x = '0;
      pen_y = '0;
      start_x = '0;
      start_y = '0;
      word_digits = 0;
      mode = M_LINE_START;
      coord_on_line = 1'b0;
      dnum = 7'd0;
      dseen = 2'd0;
      events_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[PADDR_BITS-1:2])
          REG_X_DECIMALS: xdec = pwdata[2:0];
          REG_Y_DECIMALS: ydec = pwdata[2:0];
          REG_INCH_UNITS: inch = pwdata[0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (events_due.size() == 0) begin
          report_mismatch($sformatf("event beat %0d code %0d with none expected",
                                    event_res, code_number));
        end else begin
          want = events_due.pop_front();
          if (event_res !== want.event_res)
            report_mismatch($sformatf("event_res got %0d expected %0d",
                                      event_res, want.event_res));
          if (x_from !== want.x_from)
            report_mismatch($sformatf("x_from got %0d expected %0d", x_from, want.x_from));
          if (y_from !== want.y_from)
            report_mismatch($sformatf("y_from got %0d expected %0d", y_from, want.y_from));
          if (x_to !== want.x_to)
            report_mismatch($sformatf("x_to got %0d expected %0d", x_to, want.x_to));
          if (y_to !== want.y_to)
            report_mismatch($sformatf("y_to got %0d expected %0d", y_to, want.y_to));
          if (code_number !== want.code_number)
            report_mismatch($sformatf("code_number got %0d expected %0d",
                                      code_number, want.code_number));
        end
      end
      if (in_valid && !in_stall) parse_char(ch);
    end
    events_waiting = events_due.size();
  end

endmodule

// File: bench/plot_command_stream_parser_core_test.sv
`timescale 1ns / 1ps
// Testbench top for plot_command_stream_parser_core: clock, reset, register writes
// and character stimulus. Depends on pcsp_pkg and plot_command_stream_parser_core_check.

module plot_command_stream_parser_core_test;
  import pcsp_pkg::*;

  localparam int HOLD_CYCLES = 400;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_CHARS = 205;
  localparam int PHASES      = 6;
  localparam logic [7:0] CH_STAR = 8'h2A;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_BITS-1:0] paddr = '0;
  logic [PDATA_BITS-1:0] pwdata = '0;
  logic [PDATA_BITS-1:0] prdata;
  logic                  pready;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [7:0]            ch = 8'd0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            event_res;
  logic [COORD_BITS-1:0] x_from, y_from, x_to, y_to;
  logic [6:0]            code_number;

  int mismatches;
  int events_waiting;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_asked = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int chars_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  plot_command_stream_parser_core u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .x_from(x_from), .y_from(y_from), .x_to(x_to), .y_to(y_to),
    .code_number(code_number)
  );

  plot_command_stream_parser_core_check u_check (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata),
    .in_valid(in_valid), .in_stall(in_stall), .ch(ch),
    .out_valid(out_valid), .out_stall(out_stall),
    .event_res(event_res), .x_from(x_from), .y_from(y_from), .x_to(x_to), .y_to(y_to),
    .code_number(code_number),
    .mismatches(mismatches), .events_waiting(events_waiting)
  );

  // receiver: random stalls, or a long hold-off when one is asked for
  always @(negedge clk) begin
    if (hold_seen != hold_asked) begin
      hold_seen = hold_asked;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog: cycles with no beat and no register access
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // one character beat; returns just after the edge that takes it
  task automatic send_char(input logic [7:0] c);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    ch <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chars_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  // stop sending, wait for every event, then a few cycles more
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (events_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // setup then access cycle
  task automatic cfg_write(input logic [1:0] idx, input logic [PDATA_BITS-1:0] v);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= v;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // mostly short words, now and then long enough to saturate
  task automatic send_digits();
    int n;
    n = ($urandom_range(7) == 0) ? $urandom_range(13, 9) : $urandom_range(8);
    repeat (n) send_char(CH_0 + 8'($urandom_range(9)));
  endtask

  task automatic end_line();
    if ($urandom_range(3) == 0) send_char(CH_CR);
    send_char(CH_LF);
  endtask

  // one random line of text
  task automatic send_line();
    int         kind, len;
    logic [7:0] b;
    kind = $urandom_range(99);
    if (kind < 50) begin
      // plot line: coordinate words, then mostly D01..D03
      if ($urandom_range(3) != 0) begin
        send_char(CH_X);
        send_digits();
      end
      if ($urandom_range(3) != 0) begin
        send_char(CH_Y);
        send_digits();
      end
      send_char(CH_D);
      send_char(CH_0);
      send_char(CH_0 + 8'(($urandom_range(4) == 0) ? $urandom_range(9) : $urandom_range(3, 1)));
      if ($urandom_range(1) == 1) send_char(CH_STAR);
    end else if (kind < 65) begin
      // aperture select D10..D99
      send_char(CH_D);
      send_char(CH_0 + 8'($urandom_range(9, 1)));
      send_char(CH_0 + 8'($urandom_range(9)));
      if ($urandom_range(1) == 1) send_char(CH_STAR);
    end else if (kind < 73) begin
      // skipped line
      send_char(CH_PCT);
      len = $urandom_range(6);
      repeat (len) begin
        b = 8'($urandom_range(255));
        send_char((b == CH_LF) ? CH_STAR : b);
      end
    end else if (kind < 85) begin
      // broken D words
      case ($urandom_range(3))
        0: send_char(CH_D);
        1: begin
          send_char(CH_D);
          send_char(CH_0 + 8'($urandom_range(9)));
        end
        2: begin
          send_char(CH_D);
          send_char($urandom_range(1) ? CH_X : 8'($urandom_range(255, 58)));
          send_char(8'($urandom_range(255)));
        end
        default: begin
          send_char(CH_D);
          send_char(CH_0 + 8'($urandom_range(9)));
          send_char($urandom_range(1) ? CH_Y : 8'($urandom_range(255, 58)));
        end
      endcase
    end else begin
      // noise: any byte, line ends included
      len = $urandom_range(6, 1);
      repeat (len) send_char(8'($urandom_range(255)));
    end
    end_line();
  endtask

  initial begin
    logic [2:0] xd, yd;
    logic       inch;
    int         phase_start;
    bit         hold_done;
    hold_done = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: skipped line with extreme bytes, saturated X word, empty Y word,
    // carriage return, percent mid-line, D word cut by line end,
    // non-digit D code, top aperture number
    send_char(CH_PCT);
    send_char(8'h00);
    send_char(8'hFF);
    send_char(CH_LF);
    send_text("X12345678901Y");
    send_char(CH_CR);
    send_text("%D1");
    send_char(CH_LF);
    send_text("DA7D99");
    send_char(CH_LF);

    // random phases: each with its own register setting, idling pattern chosen by phase mod 4
    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p)
        0: begin xd = 3'd0; yd = 3'd0; inch = 1'b0; end
        1: begin xd = 3'd6; yd = 3'd6; inch = 1'b1; end
        2: begin xd = 3'd7; yd = 3'd7; inch = 1'b1; end
        3: begin xd = 3'd3; yd = 3'd5; inch = 1'b0; end
        4: begin
          xd = 3'($urandom_range(7));
          yd = 3'($urandom_range(7));
          inch = 1'($urandom_range(1));
        end
        default: begin xd = 3'd6; yd = 3'd0; inch = 1'b0; end
      endcase
      cfg_write(REG_X_DECIMALS, PDATA_BITS'(xd));
      cfg_write(REG_Y_DECIMALS, PDATA_BITS'(yd));
      cfg_write(REG_INCH_UNITS, PDATA_BITS'(inch));
      case (p % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 75; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 75; end
        default: begin send_idle_pct = 23; stall_pct = 23; end
      endcase
      phase_start = chars_sent;
      while (chars_sent - phase_start < PHASE_CHARS) begin
        // long receiver hold-off while characters keep coming
        if (p == 0 && !hold_done && chars_sent - phase_start > 40) begin
          hold_asked++;
          hold_done = 1'b1;
        end
        send_line();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
